[sv/grid_ray_cast_hit_point_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the grid ray cast core
// Concurrent assertion shorthands, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_CAST_HIT_POINT_CORE_MACROS_SVH
`define GRID_RAY_CAST_HIT_POINT_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define GRC_ASSERT_IMP(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("grc assertion failed");
`define GRC_ASSERT_NXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("grc assertion failed");
`else
`define GRC_ASSERT_IMP(lbl, ant, con)
`define GRC_ASSERT_NXT(lbl, ant, con)
`endif

`endif

[sv/grc_pkg.sv]
// ----------------------------------------------------------------------------
// grc_pkg
// Types, codes and constants shared by the grid ray cast modules.
// ----------------------------------------------------------------------------
package grc_pkg;

    localparam int MAP_DEPTH       = 4096;
    localparam int ADDR_W          = 12;
    localparam int MAP_WIDTH_DEF   = 64;
    localparam int MAP_HEIGHT_DEF  = 64;
    localparam int TILE_SIZE_DEF   = 32;
    localparam int FRAC_ONE        = 16;
    localparam int DIV_N_W         = 34;
    localparam int DIV_D_W         = 17;

    localparam logic OPC_WRITE = 1'b0;
    localparam logic OPC_CAST  = 1'b1;

    localparam logic [1:0] EDGE_TOP    = 2'd0;
    localparam logic [1:0] EDGE_LEFT   = 2'd1;
    localparam logic [1:0] EDGE_BOTTOM = 2'd2;
    localparam logic [1:0] EDGE_RIGHT  = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic [11:0]        cell_index;
        logic               cell_solid;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] stop_x;
        logic signed [15:0] stop_y;
    } t_out;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_WRITE,
        OP_LOAD,
        OP_FDIV_START,
        OP_FDIV_STORE,
        OP_WALK_INIT,
        OP_READ,
        OP_STEP,
        OP_HIT_INIT,
        OP_E_SETUP,
        OP_E_MUL1,
        OP_E_MUL2,
        OP_E_NB,
        OP_E_TEST,
        OP_DIV_START,
        OP_E_POINT,
        OP_E_SQ1,
        OP_E_SQ2,
        OP_E_CMP,
        OP_OUT_HIT,
        OP_OUT_MISS
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic solid;
        logic last;
        logic div_done;
        logic ok;
        logic out_free;
    } t_stat;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_FDIV_START,
        S_FDIV_WAIT,
        S_WALK_INIT,
        S_READ,
        S_CHECK,
        S_HIT_INIT,
        S_E_SETUP,
        S_E_MUL1,
        S_E_MUL2,
        S_E_NB,
        S_E_TEST,
        S_E_CHK,
        S_E_DIV,
        S_E_SQ1,
        S_E_SQ2,
        S_E_CMP,
        S_E_NEXT,
        S_OUT_HIT,
        S_OUT_MISS
    } t_state;

    function automatic logic signed [15:0] sat16(input logic signed [22:0] v);
        logic signed [15:0] r;
        if (v > 23'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -23'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

[sv/grc_ram.sv]
// ----------------------------------------------------------------------------
// grc_ram
// Single-port RAM with one write or read per cycle and registered read data.
// ----------------------------------------------------------------------------
module grc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/grc_div.sv]
// ----------------------------------------------------------------------------
// grc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [grc_pkg::DIV_N_W-1:0]  i_dividend,
    input  logic [grc_pkg::DIV_D_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [grc_pkg::DIV_N_W-1:0]  o_quot
);

    localparam int NW = grc_pkg::DIV_N_W;
    localparam int DW = grc_pkg::DIV_D_W;
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;

    assign rem_sh = {r_rem, r_q[NW-1]};
    assign diff   = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CW'(NW);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= diff[DW] ? rem_sh[DW-1:0] : diff[DW-1:0];
            r_q   <= {r_q[NW-2:0], ~diff[DW]};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[sv/grc_dpath.sv]
// ----------------------------------------------------------------------------
// grc_dpath
// Map memory, cell walk registers, edge intersection arithmetic and output.
// ----------------------------------------------------------------------------
module grc_dpath #(
    parameter int MAP_WIDTH  = grc_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = grc_pkg::MAP_HEIGHT_DEF,
    parameter int TILE_SIZE  = grc_pkg::TILE_SIZE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  grc_pkg::t_cmd  i_cmd,
    input  grc_pkg::t_in   i_in_data,
    input  logic           i_out_stall,
    output grc_pkg::t_stat o_stat,
    output logic           o_out_valid,
    output grc_pkg::t_out  o_out_data
);

    localparam int SPAN = TILE_SIZE * grc_pkg::FRAC_ONE;
    localparam int AW   = grc_pkg::ADDR_W;
    localparam int NW   = grc_pkg::DIV_N_W;
    localparam int DW   = grc_pkg::DIV_D_W;

    // Cell coordinates come from a reciprocal multiplication that is exact
    // for every 16-bit magnitude.
    localparam int     FL_SH = 28;
    localparam longint FL_M  = ((longint'(1) <<< FL_SH) + longint'(SPAN) - 1)
                               / longint'(SPAN);

    // Map memory and clearing pass.
    logic [AW-1:0] r_clr;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic          ram_wd;
    logic          ram_rd;

    // Segment and walk state.
    logic signed [15:0] r_ox, r_oy, r_ex, r_ey;
    logic signed [16:0] r_ddx, r_ddy;
    logic signed [11:0] r_x, r_y, r_x1, r_y1;
    logic [9:0]         r_dx, r_dy;
    logic signed [11:0] r_err;
    logic [10:0]        r_n;
    logic               r_xpos, r_ypos;
    logic               r_inmap;
    logic               r_dneg;
    logic [11:0]        r_fq;

    // Edge arithmetic.
    logic signed [22:0] r_tx, r_ty, r_q1x, r_q1y;
    logic signed [22:0] r_a, r_b, r_na;
    logic signed [17:0] r_den;
    logic signed [40:0] r_nb, r_prod, r_t;
    logic               r_horiz, r_ok, r_found;
    logic signed [22:0] r_ix, r_iy, r_bx, r_by;
    logic [33:0]        r_bd;

    // Output register.
    logic          r_ovalid;
    grc_pkg::t_out r_opay;

    logic [16:0]        cell_idx;
    logic               inmap;
    logic               div_start;
    logic [NW-1:0]      div_n;
    logic [DW-1:0]      div_d;
    logic               div_done;
    logic [NW-1:0]      div_q;
    logic signed [15:0] fsel_v;
    logic signed [16:0] fsel_e;
    logic [16:0]        fsel_mag;
    logic [39:0]        fl_prod;
    logic               fl_nz;
    logic signed [11:0] fl_q;
    logic signed [11:0] fl_v;
    logic signed [11:0] dxs, dys;
    logic [9:0]         dxa, dya;
    logic [22:0]        tx_u, ty_u;
    logic signed [22:0] ox_e, oy_e;
    logic               horiz;
    logic signed [22:0] q1x, q1y, ea, eb;
    logic signed [22:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [40:0] mul_p;
    logic signed [40:0] nbv;
    logic               den_neg;
    logic signed [40:0] nb_lim;
    logic signed [40:0] prod_mag;
    logic signed [17:0] rq, rr;
    logic signed [22:0] dfx, dfy;
    logic [33:0]        sq_dist;
    logic               out_free;

    grc_ram #(
        .WIDTH (1),
        .DEPTH (grc_pkg::MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wd),
        .o_rdata (ram_rd)
    );

    grc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign cell_idx = 17'(r_y[7:0]) * 17'(MAP_WIDTH) + 17'(r_x[7:0]);
    assign inmap    = !r_x[11] && !r_y[11]
                   && ($unsigned(r_x) < 12'(MAP_WIDTH))
                   && ($unsigned(r_y) < 12'(MAP_HEIGHT))
                   && (cell_idx < 17'(grc_pkg::MAP_DEPTH));

    always_comb begin
        ram_we   = 1'b0;
        ram_addr = r_clr;
        ram_wd   = 1'b0;
        case (i_cmd.op)
            grc_pkg::OP_CLEAR: begin
                ram_we = 1'b1;
            end
            grc_pkg::OP_WRITE: begin
                ram_we   = 1'b1;
                ram_addr = i_in_data.cell_index;
                ram_wd   = i_in_data.cell_solid;
            end
            grc_pkg::OP_READ: begin
                ram_addr = cell_idx[AW-1:0];
            end
            default: begin
                ram_addr = r_clr;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.sel)
            2'd0:    fsel_v = r_ox;
            2'd1:    fsel_v = r_oy;
            2'd2:    fsel_v = r_ex;
            default: fsel_v = r_ey;
        endcase
    end

    assign fsel_e   = 17'(fsel_v);
    assign fsel_mag = fsel_e[16] ? $unsigned(-fsel_e) : $unsigned(fsel_e);
    assign fl_prod  = 40'(fsel_mag) * 40'(FL_M);
    assign fl_nz    = (fsel_mag != 17'(r_fq) * 17'(SPAN));
    assign prod_mag = r_prod[40] ? -r_prod : r_prod;

    assign div_start = (i_cmd.op == grc_pkg::OP_DIV_START);
    assign div_n     = {prod_mag[32:0], 1'b0} + NW'($unsigned(r_den));
    assign div_d     = {r_den[15:0], 1'b0};

    assign fl_q = r_fq;
    assign fl_v = !r_dneg ? fl_q : (fl_nz ? -(fl_q + 12'sd1) : -fl_q);

    assign dxs = r_x1 - r_x;
    assign dys = r_y1 - r_y;
    assign dxa = dxs[11] ? 10'(-dxs) : 10'(dxs);
    assign dya = dys[11] ? 10'(-dys) : 10'(dys);

    assign tx_u = 23'(r_x[7:0]) * 23'(SPAN);
    assign ty_u = 23'(r_y[7:0]) * 23'(SPAN);
    assign ox_e = 23'(r_ox);
    assign oy_e = 23'(r_oy);

    assign horiz = (i_cmd.sel == grc_pkg::EDGE_TOP) || (i_cmd.sel == grc_pkg::EDGE_BOTTOM);
    assign q1x   = (i_cmd.sel == grc_pkg::EDGE_RIGHT)  ? r_tx + 23'(SPAN) : r_tx;
    assign q1y   = (i_cmd.sel == grc_pkg::EDGE_BOTTOM) ? r_ty + 23'(SPAN) : r_ty;
    assign ea    = oy_e - q1y;
    assign eb    = ox_e - q1x;

    assign dfx = r_ix - ox_e;
    assign dfy = r_iy - oy_e;

    always_comb begin
        case (i_cmd.op)
            grc_pkg::OP_E_MUL1: begin
                mul_a = r_a;
                mul_b = 18'(r_ddx);
            end
            grc_pkg::OP_E_MUL2: begin
                mul_a = r_b;
                mul_b = 18'(r_ddy);
            end
            grc_pkg::OP_E_TEST: begin
                mul_a = r_na;
                mul_b = r_horiz ? 18'(r_ddx) : 18'(r_ddy);
            end
            grc_pkg::OP_E_SQ1: begin
                mul_a = dfx;
                mul_b = dfx[17:0];
            end
            default: begin
                mul_a = dfy;
                mul_b = dfy[17:0];
            end
        endcase
    end

    assign mul_p    = 41'(mul_a) * 41'(mul_b);
    assign nbv      = r_t - r_prod;
    assign den_neg  = r_den[17];
    assign nb_lim   = 41'(r_den) * 41'(SPAN);
    assign rq       = 18'(div_q[16:0]);
    assign rr       = r_dneg ? -rq : rq;
    assign sq_dist  = 34'($unsigned(r_t[33:0])) + 34'($unsigned(r_prod[33:0]));
    assign out_free = !r_ovalid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.op == grc_pkg::OP_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if ((i_cmd.op == grc_pkg::OP_OUT_HIT) || (i_cmd.op == grc_pkg::OP_OUT_MISS)) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            grc_pkg::OP_LOAD: begin
                r_ox  <= i_in_data.origin_x;
                r_oy  <= i_in_data.origin_y;
                r_ex  <= i_in_data.end_x;
                r_ey  <= i_in_data.end_y;
                r_ddx <= 17'(i_in_data.end_x) - 17'(i_in_data.origin_x);
                r_ddy <= 17'(i_in_data.end_y) - 17'(i_in_data.origin_y);
            end
            grc_pkg::OP_FDIV_START: begin
                r_dneg <= fsel_v[15];
                r_fq   <= fl_prod[FL_SH +: 12];
            end
            grc_pkg::OP_FDIV_STORE: begin
                case (i_cmd.sel)
                    2'd0:    r_x  <= fl_v;
                    2'd1:    r_y  <= fl_v;
                    2'd2:    r_x1 <= fl_v;
                    default: r_y1 <= fl_v;
                endcase
            end
            grc_pkg::OP_WALK_INIT: begin
                r_dx   <= dxa;
                r_dy   <= dya;
                r_xpos <= r_x1 > r_x;
                r_ypos <= r_y1 > r_y;
                r_err  <= 12'(dxa) - 12'(dya);
                r_n    <= 11'd1 + 11'(dxa) + 11'(dya);
            end
            grc_pkg::OP_READ: begin
                r_inmap <= inmap;
            end
            grc_pkg::OP_STEP: begin
                if (r_err > 12'sd0) begin
                    r_x   <= r_xpos ? r_x + 12'sd1 : r_x - 12'sd1;
                    r_err <= r_err - 12'({r_dy, 1'b0});
                end else begin
                    r_y   <= r_ypos ? r_y + 12'sd1 : r_y - 12'sd1;
                    r_err <= r_err + 12'({r_dx, 1'b0});
                end
                r_n <= r_n - 1'b1;
            end
            grc_pkg::OP_HIT_INIT: begin
                r_tx    <= $signed(tx_u);
                r_ty    <= $signed(ty_u);
                r_bx    <= $signed(tx_u + 23'(SPAN / 2));
                r_by    <= $signed(ty_u + 23'(SPAN / 2));
                r_found <= 1'b0;
            end
            grc_pkg::OP_E_SETUP: begin
                r_horiz <= horiz;
                r_q1x   <= q1x;
                r_q1y   <= q1y;
                r_a     <= ea;
                r_b     <= eb;
                r_den   <= horiz ? -18'(r_ddy) : 18'(r_ddx);
                r_na    <= horiz ? ea : -eb;
            end
            grc_pkg::OP_E_MUL1: begin
                r_prod <= mul_p;
            end
            grc_pkg::OP_E_MUL2: begin
                r_t    <= r_prod;
                r_prod <= mul_p;
            end
            grc_pkg::OP_E_NB: begin
                r_nb  <= den_neg ? -nbv : nbv;
                r_den <= den_neg ? -r_den : r_den;
                r_na  <= den_neg ? -r_na : r_na;
            end
            grc_pkg::OP_E_TEST: begin
                r_ok <= (r_den != '0) && !r_na[22] && (r_na <= 23'(r_den))
                     && !r_nb[40] && (r_nb <= nb_lim);
                r_prod <= mul_p;
            end
            grc_pkg::OP_DIV_START: begin
                r_dneg <= r_prod[40];
            end
            grc_pkg::OP_E_POINT: begin
                if (r_horiz) begin
                    r_ix <= ox_e + 23'(rr);
                    r_iy <= r_q1y;
                end else begin
                    r_ix <= r_q1x;
                    r_iy <= oy_e + 23'(rr);
                end
            end
            grc_pkg::OP_E_SQ1: begin
                r_prod <= mul_p;
            end
            grc_pkg::OP_E_SQ2: begin
                r_t    <= r_prod;
                r_prod <= mul_p;
            end
            grc_pkg::OP_E_CMP: begin
                if (!r_found || (sq_dist < r_bd)) begin
                    r_found <= 1'b1;
                    r_bd    <= sq_dist;
                    r_bx    <= r_ix;
                    r_by    <= r_iy;
                end
            end
            grc_pkg::OP_OUT_HIT: begin
                r_opay <= '{hit: 1'b1, stop_x: grc_pkg::sat16(r_bx),
                            stop_y: grc_pkg::sat16(r_by)};
            end
            grc_pkg::OP_OUT_MISS: begin
                r_opay <= '{hit: 1'b0, stop_x: r_ex, stop_y: r_ey};
            end
            default: begin
                r_t <= r_t;
            end
        endcase
    end

    assign o_stat = '{
        clr_last: (r_clr == AW'(grc_pkg::MAP_DEPTH - 1)),
        solid:    r_inmap && ram_rd,
        last:     (r_n == 11'd1),
        div_done: div_done,
        ok:       r_ok,
        out_free: out_free
    };

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_opay;

endmodule

[sv/grc_ctrl.sv]
// ----------------------------------------------------------------------------
// grc_ctrl
// Sequencer for map clearing, map writes, the cell walk and the edge tests.
// ----------------------------------------------------------------------------
module grc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_opcode,
    input  grc_pkg::t_stat i_stat,
    output logic           o_in_stall,
    output grc_pkg::t_cmd  o_cmd
);

    grc_pkg::t_state r_state, n_state;
    logic [1:0]      r_sel, n_sel;
    grc_pkg::t_op    op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= grc_pkg::S_CLEAR;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            grc_pkg::S_CLEAR:      if (i_stat.clr_last) n_state = grc_pkg::S_IDLE;
            grc_pkg::S_IDLE: begin
                if (i_in_valid && (i_opcode == grc_pkg::OPC_CAST)) begin
                    n_state = grc_pkg::S_FDIV_START;
                end
            end
            grc_pkg::S_FDIV_START: n_state = grc_pkg::S_FDIV_WAIT;
            grc_pkg::S_FDIV_WAIT: begin
                n_state = (r_sel == 2'd3) ? grc_pkg::S_WALK_INIT : grc_pkg::S_FDIV_START;
            end
            grc_pkg::S_WALK_INIT:  n_state = grc_pkg::S_READ;
            grc_pkg::S_READ:       n_state = grc_pkg::S_CHECK;
            grc_pkg::S_CHECK: begin
                if (i_stat.solid) begin
                    n_state = grc_pkg::S_HIT_INIT;
                end else if (i_stat.last) begin
                    n_state = grc_pkg::S_OUT_MISS;
                end else begin
                    n_state = grc_pkg::S_READ;
                end
            end
            grc_pkg::S_HIT_INIT:   n_state = grc_pkg::S_E_SETUP;
            grc_pkg::S_E_SETUP:    n_state = grc_pkg::S_E_MUL1;
            grc_pkg::S_E_MUL1:     n_state = grc_pkg::S_E_MUL2;
            grc_pkg::S_E_MUL2:     n_state = grc_pkg::S_E_NB;
            grc_pkg::S_E_NB:       n_state = grc_pkg::S_E_TEST;
            grc_pkg::S_E_TEST:     n_state = grc_pkg::S_E_CHK;
            grc_pkg::S_E_CHK:      n_state = i_stat.ok ? grc_pkg::S_E_DIV : grc_pkg::S_E_NEXT;
            grc_pkg::S_E_DIV:      if (i_stat.div_done) n_state = grc_pkg::S_E_SQ1;
            grc_pkg::S_E_SQ1:      n_state = grc_pkg::S_E_SQ2;
            grc_pkg::S_E_SQ2:      n_state = grc_pkg::S_E_CMP;
            grc_pkg::S_E_CMP:      n_state = grc_pkg::S_E_NEXT;
            grc_pkg::S_E_NEXT: begin
                n_state = (r_sel == grc_pkg::EDGE_RIGHT) ? grc_pkg::S_OUT_HIT
                                                         : grc_pkg::S_E_SETUP;
            end
            grc_pkg::S_OUT_HIT:    if (i_stat.out_free) n_state = grc_pkg::S_IDLE;
            grc_pkg::S_OUT_MISS:   if (i_stat.out_free) n_state = grc_pkg::S_IDLE;
            default:               n_state = grc_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        op    = grc_pkg::OP_NONE;
        n_sel = r_sel;
        unique case (r_state)
            grc_pkg::S_CLEAR:      op = grc_pkg::OP_CLEAR;
            grc_pkg::S_IDLE: begin
                n_sel = '0;
                if (i_in_valid) begin
                    op = (i_opcode == grc_pkg::OPC_CAST) ? grc_pkg::OP_LOAD
                                                         : grc_pkg::OP_WRITE;
                end
            end
            grc_pkg::S_FDIV_START: op = grc_pkg::OP_FDIV_START;
            grc_pkg::S_FDIV_WAIT: begin
                op = grc_pkg::OP_FDIV_STORE;
                if (r_sel != 2'd3) n_sel = r_sel + 1'b1;
            end
            grc_pkg::S_WALK_INIT:  op = grc_pkg::OP_WALK_INIT;
            grc_pkg::S_READ:       op = grc_pkg::OP_READ;
            grc_pkg::S_CHECK: begin
                if (!i_stat.solid && !i_stat.last) op = grc_pkg::OP_STEP;
            end
            grc_pkg::S_HIT_INIT: begin
                op    = grc_pkg::OP_HIT_INIT;
                n_sel = grc_pkg::EDGE_TOP;
            end
            grc_pkg::S_E_SETUP:    op = grc_pkg::OP_E_SETUP;
            grc_pkg::S_E_MUL1:     op = grc_pkg::OP_E_MUL1;
            grc_pkg::S_E_MUL2:     op = grc_pkg::OP_E_MUL2;
            grc_pkg::S_E_NB:       op = grc_pkg::OP_E_NB;
            grc_pkg::S_E_TEST:     op = grc_pkg::OP_E_TEST;
            grc_pkg::S_E_CHK:      if (i_stat.ok) op = grc_pkg::OP_DIV_START;
            grc_pkg::S_E_DIV:      if (i_stat.div_done) op = grc_pkg::OP_E_POINT;
            grc_pkg::S_E_SQ1:      op = grc_pkg::OP_E_SQ1;
            grc_pkg::S_E_SQ2:      op = grc_pkg::OP_E_SQ2;
            grc_pkg::S_E_CMP:      op = grc_pkg::OP_E_CMP;
            grc_pkg::S_E_NEXT: begin
                if (r_sel != grc_pkg::EDGE_RIGHT) n_sel = r_sel + 1'b1;
            end
            grc_pkg::S_OUT_HIT:    if (i_stat.out_free) op = grc_pkg::OP_OUT_HIT;
            grc_pkg::S_OUT_MISS:   if (i_stat.out_free) op = grc_pkg::OP_OUT_MISS;
            default:               op = grc_pkg::OP_NONE;
        endcase
    end

    assign o_cmd      = '{op: op, sel: r_sel};
    assign o_in_stall = (r_state != grc_pkg::S_IDLE);

endmodule

[sv/grid_ray_cast_hit_point_core.sv]
// ----------------------------------------------------------------------------
// grid_ray_cast_hit_point_core
// Tile map ray cast returning the hit point on the first solid tile.
//
// The input channel carries one beat per map write or cast; the output
// channel carries one beat per cast and none per write. Both use valid and
// stall. A write is done while the core stays idle, so the input does not
// stall for it. A cast finds its four cell coordinates in alternating
// start and store steps, walks the visited cells (1 + |dx| + |dy| cells at
// most, 255 at most) with a read and a check step per cell, and on a solid
// tile runs a hit set-up step and then set-up, multiply, numerator, test,
// check and next steps for each of the four tile sides; each side that the
// segment touches also waits on the radix-2 divider, then takes square and
// compare steps. The core has a single divider and a single map read port.
// The next beat can be taken in the cycle after the result is posted. One
// cast is in work at a time. After reset the map is cleared in a pass over
// all 4096 cells, one cell a cycle, and the input stalls until it ends. The
// result sits in an output register; when the receiver stalls, a following
// cast finishes, then waits for the register to drain with input stalled.
// ----------------------------------------------------------------------------
`include "grid_ray_cast_hit_point_core_macros.svh"

module grid_ray_cast_hit_point_core #(
    parameter int MAP_WIDTH  = grc_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = grc_pkg::MAP_HEIGHT_DEF,
    parameter int TILE_SIZE  = grc_pkg::TILE_SIZE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  grc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output grc_pkg::t_out o_out_data
);

    grc_pkg::t_cmd  cmd;
    grc_pkg::t_stat stat;
    logic           out_post;
    logic           cast_take;

    grc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    grc_dpath #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT),
        .TILE_SIZE  (TILE_SIZE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign out_post  = (cmd.op == grc_pkg::OP_OUT_HIT) || (cmd.op == grc_pkg::OP_OUT_MISS);
    assign cast_take = i_in_valid && !o_in_stall && (i_in_data.opcode == grc_pkg::OPC_CAST);

    `GRC_ASSERT_IMP(a_out_slot_free, out_post, stat.out_free)
    `GRC_ASSERT_NXT(a_cast_holds_input, cast_take, o_in_stall)
    `GRC_ASSERT_NXT(a_result_posted, out_post, o_out_valid)

endmodule

[test/grid_ray_cast_hit_point_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for grid_ray_cast_hit_point_core
// Drives map writes and segment casts through the valid/stall input channel.
// A scoreboard keeps its own copy of the collision map and predicts each cast
// result. Every output beat is checked field by field against the oldest
// prediction. The run covers several sender and receiver idle mixes and one
// long receiver hold-off.
// ----------------------------------------------------------------------------
module grid_ray_cast_hit_point_core_tb;

    localparam longint SPAN      = 512;
    localparam int     MAP_CELLS = 64;
    localparam longint LIMIT     = 3000000;

    class hit_point_scoreboard;
        bit            solid_map[grc_pkg::MAP_DEPTH];
        grc_pkg::t_out pending[$];
        int            errors;

        function longint fdiv(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0) q--;
            return q;
        endfunction

        function longint rdiv(longint n, longint d);
            if (n >= 0) return (2 * n + d) / (2 * d);
            return -((-2 * n + d) / (2 * d));
        endfunction

        function logic signed [15:0] clamp16(longint v);
            if (v > 32767) return 16'sh7fff;
            if (v < -32768) return 16'sh8000;
            return v[15:0];
        endfunction

        function bit blocked(longint cx, longint cy);
            if (cx < 0 || cy < 0 || cx >= MAP_CELLS || cy >= MAP_CELLS) return 0;
            return solid_map[cx + cy * MAP_CELLS];
        endfunction

        function grc_pkg::t_out trace_segment(grc_pkg::t_in it);
            longint ox, oy, ex, ey, x0, y0, x1, y1, dx, dy, xi, yi, err, x, y, n;
            longint ddx, ddy, tx, ty, bx, by, bd, d, ix, iy;
            longint qx1, qy1, qx2, qy2, sx, sy, den, na, nb;
            bit            found;
            grc_pkg::t_out r;
            ox = it.origin_x; oy = it.origin_y; ex = it.end_x; ey = it.end_y;
            x0 = fdiv(ox, SPAN); y0 = fdiv(oy, SPAN);
            x1 = fdiv(ex, SPAN); y1 = fdiv(ey, SPAN);
            dx = x1 > x0 ? x1 - x0 : x0 - x1;
            dy = y1 > y0 ? y1 - y0 : y0 - y1;
            xi = x1 > x0 ? 1 : -1;
            yi = y1 > y0 ? 1 : -1;
            err = dx - dy;
            ddx = ex - ox; ddy = ey - oy;
            x = x0; y = y0;
            for (n = 1 + dx + dy; n > 0; n--) begin
                if (blocked(x, y)) begin
                    tx = x * SPAN; ty = y * SPAN;
                    bx = tx + SPAN / 2; by = ty + SPAN / 2; bd = 0;
                    found = 0;
                    for (int k = 0; k < 4; k++) begin
                        case (k)
                            grc_pkg::EDGE_TOP: begin
                                qx1 = tx; qy1 = ty; qx2 = tx + SPAN; qy2 = ty;
                            end
                            grc_pkg::EDGE_LEFT: begin
                                qx1 = tx; qy1 = ty; qx2 = tx; qy2 = ty + SPAN;
                            end
                            grc_pkg::EDGE_BOTTOM: begin
                                qx1 = tx; qy1 = ty + SPAN; qx2 = tx + SPAN; qy2 = ty + SPAN;
                            end
                            default: begin
                                qx1 = tx + SPAN; qy1 = ty; qx2 = tx + SPAN; qy2 = ty + SPAN;
                            end
                        endcase
                        sx = qx2 - qx1; sy = qy2 - qy1;
                        den = sy * ddx - sx * ddy;
                        na = sx * (oy - qy1) - sy * (ox - qx1);
                        nb = ddx * (oy - qy1) - ddy * (ox - qx1);
                        if (den == 0) continue;
                        if (den < 0) begin
                            den = -den; na = -na; nb = -nb;
                        end
                        if (na < 0 || na > den || nb < 0 || nb > den) continue;
                        ix = ox + rdiv(na * ddx, den);
                        iy = oy + rdiv(na * ddy, den);
                        d = (ix - ox) * (ix - ox) + (iy - oy) * (iy - oy);
                        if (!found || d < bd) begin
                            found = 1; bd = d; bx = ix; by = iy;
                        end
                    end
                    r.hit = 1'b1;
                    r.stop_x = clamp16(bx);
                    r.stop_y = clamp16(by);
                    return r;
                end
                if (err > 0) begin
                    x += xi; err -= 2 * dy;
                end else begin
                    y += yi; err += 2 * dx;
                end
            end
            r.hit = 1'b0;
            r.stop_x = it.end_x;
            r.stop_y = it.end_y;
            return r;
        endfunction

        function void note_input(grc_pkg::t_in it);
            if (it.opcode == grc_pkg::OPC_WRITE) solid_map[it.cell_index] = it.cell_solid;
            else pending.push_back(trace_segment(it));
        endfunction

        function void check_result(grc_pkg::t_out got);
            grc_pkg::t_out want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result: hit=%0d x=%0d y=%0d",
                                           got.hit, got.stop_x, got.stop_y);
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit || got.stop_x !== want.stop_x ||
                got.stop_y !== want.stop_y) begin
                errors++;
                if (errors <= 10) $display(
                    "Mismatch: expected hit=%0d x=%0d y=%0d, got hit=%0d x=%0d y=%0d",
                    want.hit, want.stop_x, want.stop_y, got.hit, got.stop_x, got.stop_y);
            end
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    grc_pkg::t_in   i_in_data;
    logic           o_out_valid;
    logic           i_out_stall;
    grc_pkg::t_out  o_out_data;

    hit_point_scoreboard sb;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_cycles;
    longint  cycle_count;

    grid_ray_cast_hit_point_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: stall pattern set at the falling edge, beats checked at the rising edge.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles = hold_cycles - 1;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = ($urandom_range(99) < recv_stall_pct);
            end
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
        end
    end

    task automatic send_beat(grc_pkg::t_in it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data = it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_write(logic [11:0] idx, logic solid);
        grc_pkg::t_in it;
        it.origin_x = 16'($urandom());
        it.origin_y = 16'($urandom());
        it.end_x = 16'($urandom());
        it.end_y = 16'($urandom());
        it.opcode = grc_pkg::OPC_WRITE;
        it.cell_index = idx;
        it.cell_solid = solid;
        send_beat(it);
    endtask

    task automatic send_cast(logic signed [15:0] ox, logic signed [15:0] oy,
                             logic signed [15:0] ex, logic signed [15:0] ey);
        grc_pkg::t_in it;
        it.opcode = grc_pkg::OPC_CAST;
        it.cell_index = 12'($urandom());
        it.cell_solid = 1'($urandom());
        it.origin_x = ox; it.origin_y = oy;
        it.end_x = ex; it.end_y = ey;
        send_beat(it);
    endtask

    function automatic logic signed [15:0] near_coord(logic signed [15:0] base);
        int v;
        v = int'(base) + int'($urandom_range(3072)) - 1536;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic send_random();
        int sel;
        logic signed [15:0] ox, oy;
        sel = int'($urandom_range(99));
        if (sel < 25) begin
            if ($urandom_range(3) == 0) send_write(12'($urandom()), 1'($urandom()));
            else send_write(12'($urandom_range(4095)), $urandom_range(99) < 40);
        end else if (sel < 80) begin
            ox = 16'($urandom_range(32767)); oy = 16'($urandom_range(32767));
            send_cast(ox, oy, near_coord(ox), near_coord(oy));
        end else if (sel < 90) begin
            ox = 16'($urandom_range(32767)); oy = 16'($urandom_range(32767));
            if ($urandom_range(1) != 0) send_cast(ox, oy, ox, near_coord(oy));
            else send_cast(ox, oy, near_coord(ox), oy);
        end else begin
            send_cast(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
        end
    endtask

    task automatic run_phase(int idle, int stall, int count);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) send_random();
    endtask

    initial begin
        sb = new();
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_cast(16'sd100, 16'sd100, 16'sd9000, 16'sd7000);
        send_write(12'd0, 1'b1);
        send_write(12'd4095, 1'b1);
        send_write(12'd65, 1'b1);
        send_cast(16'sd100, 16'sd100, 16'sd100, 16'sd100);
        send_cast(16'sd200, 16'sd300, 16'sd400, 16'sd350);
        send_cast(16'sd200, 16'sd1000, 16'sd1200, 16'sd1100);
        send_cast(16'sd1000, 16'sd200, 16'sd1000, 16'sd1400);
        send_cast(16'sd200, 16'sd200, 16'sd1600, 16'sd1600);
        send_cast(16'sd1600, 16'sd1600, 16'sd200, 16'sd200);
        send_cast(16'sd1536, 16'sd1536, 16'sd512, 16'sd512);
        send_cast(16'sd32767, 16'sd32767, 16'sd32000, 16'sd32000);
        send_cast(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        send_cast(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
        send_cast(-16'sd600, -16'sd600, 16'sd300, 16'sd300);
        send_cast(-16'sd1000, 16'sd100, -16'sd10, 16'sd100);
        send_write(12'd0, 1'b0);
        send_cast(16'sd100, 16'sd100, 16'sd300, 16'sd300);
        send_write(12'd4095, 1'b0);
        send_cast(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);

        run_phase(0, 0, 120);
        run_phase(59, 0, 120);
        run_phase(0, 59, 120);
        run_phase(19, 19, 60);
        recv_stall_pct = 0;
        send_idle_pct = 0;
        hold_cycles = 5000;
        repeat (30) begin
            send_cast(16'($urandom_range(32767)), 16'($urandom_range(32767)),
                      16'($urandom_range(32767)), 16'($urandom_range(32767)));
        end
        run_phase(19, 19, 60);

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+sv
sv/grc_pkg.sv
sv/grc_ram.sv
sv/grc_div.sv
sv/grc_dpath.sv
sv/grc_ctrl.sv
sv/grid_ray_cast_hit_point_core.sv
test/grid_ray_cast_hit_point_core_tb.sv
